[rtl/bmam_pkg.sv]
// bmam_pkg: shared types and constants of the banked memory address mapper
// no dependencies; imported by every rtl module of the mapper
package bmam_pkg;

	// field widths
	localparam int unsigned ReqW    = 2;
	localparam int unsigned AddrW   = 16;
	localparam int unsigned PortW   = 16;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned RegionW = 2;
	localparam int unsigned ModelW  = 2;
	localparam int unsigned LimitW  = AddrW + 1;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned PageW   = 3;
	localparam int unsigned SlotCnt = 8;
	localparam int unsigned SlotW   = $clog2(SlotCnt);
	localparam int unsigned SlotOffW = 13;  // 8K slot
	localparam int unsigned PageOffW = 14;  // 16K page

	// I/O ports and register codes
	localparam logic [PortW-1:0] SelectPort   = 16'h243B;
	localparam logic [PortW-1:0] PagingPort   = 16'h7FFD;
	localparam logic [ByteW-1:0] SlotRegFirst = 8'h50;
	localparam logic [ByteW-1:0] SlotRegLast  = 8'h57;
	localparam logic [ByteW-1:0] Unmapped     = 8'hFF;
	localparam int unsigned      LockBit      = 5;
	localparam int unsigned      RomBit       = 4;

	// fixed RAM pages of the 16K paged model
	localparam logic [ByteW-1:0] SecondSegPage = 8'd5;
	localparam logic [ByteW-1:0] ThirdSegPage  = 8'd2;

	typedef enum logic [ReqW-1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_PORT  = 2'd2,
		REQ_NONE  = 2'd3
	} req_type_t;

	typedef enum logic [ModelW-1:0] {
		MODEL_FLAT  = 2'd0,
		MODEL_SLOT  = 2'd1,
		MODEL_PAGED = 2'd2,
		MODEL_ALT   = 2'd3   // treated as flat
	} model_t;

	typedef enum logic [RegionW-1:0] {
		REGION_FLAT  = 2'd0,
		REGION_BANK8 = 2'd1,
		REGION_RAM16 = 2'd2,
		REGION_ROM16 = 2'd3
	} region_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_MODEL     = 1'd0,
		CFG_ROM_LIMIT = 1'd1
	} cfg_idx_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;    // capture a result and apply a port write
		logic cfg_we;  // write a configuration register
	} ctrl_cmd_t;

endpackage

[rtl/banked_memory_address_mapper_unit.sv]
// banked_memory_address_mapper_unit: top level of the banked memory address mapper
// depends on bmam_pkg, bmam_ctrl and bmam_dp
//
// Translates a 16-bit processor address into region, bank and offset under the
// flat, eight 8K slot or 16K paged model, and takes I/O port writes that change
// the bank mapping. Every request transaction returns one result in the cycle after
// it is accepted, through a single result register; a new request is accepted
// every cycle while the result side keeps taking results, so throughput is one
// request per cycle. A port write takes effect for the request accepted right
// after it and returns an all-zero result. Configuration writes are accepted at
// any time and should be issued only while the unit is idle.
module banked_memory_address_mapper_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bmam_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bmam_pkg::LimitW-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bmam_pkg::ReqW-1:0]     req_type,
	input  logic [bmam_pkg::AddrW-1:0]    address,
	input  logic [bmam_pkg::PortW-1:0]    port_number,
	input  logic [bmam_pkg::ByteW-1:0]    out_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bmam_pkg::RegionW-1:0]  region,
	output logic [bmam_pkg::ByteW-1:0]    bank_number,
	output logic [bmam_pkg::AddrW-1:0]    offset,
	output logic                          write_allowed
);
	import bmam_pkg::*;

	ctrl_cmd_t cmd;

	// handshake controller
	bmam_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	// mapping datapath
	bmam_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.address       (address),
		.port_number   (port_number),
		.out_value     (out_value),
		.region        (region),
		.bank_number   (bank_number),
		.offset        (offset),
		.write_allowed (write_allowed)
	);

endmodule

[rtl/bmam_ctrl.sv]
// bmam_ctrl: handshake controller of the mapper, owns the result register state
// depends on bmam_pkg
module bmam_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	output bmam_pkg::ctrl_cmd_t cmd
);
	import bmam_pkg::*;

	typedef enum logic [1:0] {
		ST_EMPTY = 2'b01,
		ST_FULL  = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   in_fire;

	// new transaction taken while the result register is empty or draining
	assign in_ready  = (state_q == ST_EMPTY) || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = (state_q == ST_FULL);
	assign cfg_ready = 1'b1;

	assign cmd.load   = in_fire;
	assign cmd.cfg_we = cfg_valid;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_EMPTY: begin
				if (in_fire) state_d = ST_FULL;
			end
			ST_FULL: begin
				if (in_fire) state_d = ST_FULL;
				else if (out_ready) state_d = ST_EMPTY;
			end
			default: state_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_EMPTY;
		else state_q <= state_d;
	end

endmodule

[rtl/bmam_dp.sv]
// bmam_dp: mapping state, configuration registers and translation datapath
// depends on bmam_pkg; driven by bmam_ctrl commands
module bmam_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bmam_pkg::ctrl_cmd_t              cmd,
	input  logic [bmam_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [bmam_pkg::LimitW-1:0]      cfg_data,
	input  logic [bmam_pkg::ReqW-1:0]        req_type,
	input  logic [bmam_pkg::AddrW-1:0]       address,
	input  logic [bmam_pkg::PortW-1:0]       port_number,
	input  logic [bmam_pkg::ByteW-1:0]       out_value,
	output logic [bmam_pkg::RegionW-1:0]     region,
	output logic [bmam_pkg::ByteW-1:0]       bank_number,
	output logic [bmam_pkg::AddrW-1:0]       offset,
	output logic                             write_allowed
);
	import bmam_pkg::*;

	logic [ModelW-1:0]  model_q;
	logic [LimitW-1:0]  rom_limit_q;
	logic [ByteW-1:0]   slot_bank_q [SlotCnt];
	logic [ByteW-1:0]   sel_reg_q;
	logic [PageW-1:0]   top_page_q;
	logic               rom_choice_q;
	logic               locked_q;

	logic [RegionW-1:0] region_d;
	logic [ByteW-1:0]   bank_d;
	logic [AddrW-1:0]   offset_d;
	logic               wr_d;
	logic [ByteW-1:0]   slot_val;
	logic               port_req;

	assign port_req = cmd.load && (req_type == REQ_PORT);
	assign slot_val = slot_bank_q[address[AddrW-1 -: SlotW]];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q     <= MODEL_FLAT;
			rom_limit_q <= '0;
		end else if (cmd.cfg_we) begin
			case (cfg_index)
				CFG_MODEL:     model_q     <= cfg_data[ModelW-1:0];
				CFG_ROM_LIMIT: rom_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// eight-slot select/data register pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_reg_q <= '0;
			for (int i = 0; i < SlotCnt; i++) slot_bank_q[i] <= Unmapped;
		end else if (port_req && (model_q == MODEL_SLOT)) begin
			if ((port_number == SelectPort) && (sel_reg_q == '0)) begin
				sel_reg_q <= out_value;
			end else begin
				if (sel_reg_q inside {[SlotRegFirst:SlotRegLast]})
					slot_bank_q[sel_reg_q[SlotW-1:0]] <= out_value;
				sel_reg_q <= '0;
			end
		end
	end

	// 16K paging register with lock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_page_q   <= '0;
			rom_choice_q <= 1'b1;
			locked_q     <= 1'b0;
		end else if (port_req && (model_q == MODEL_PAGED) &&
		             (port_number == PagingPort) && !locked_q) begin
			top_page_q   <= out_value[PageW-1:0];
			rom_choice_q <= !out_value[RomBit];
			if (out_value[LockBit]) locked_q <= 1'b1;
		end
	end

	// address translation
	always_comb begin
		region_d = REGION_FLAT;
		bank_d   = '0;
		offset_d = '0;
		wr_d     = 1'b0;
		if (req_type inside {REQ_READ, REQ_WRITE}) begin
			offset_d = address;
			wr_d     = ({1'b0, address} >= rom_limit_q);
			case (model_q)
				MODEL_SLOT: begin
					if (slot_val != Unmapped) begin
						region_d = REGION_BANK8;
						bank_d   = slot_val;
						offset_d = {{(AddrW-SlotOffW){1'b0}}, address[SlotOffW-1:0]};
					end
				end
				MODEL_PAGED: begin
					offset_d = {{(AddrW-PageOffW){1'b0}}, address[PageOffW-1:0]};
					region_d = REGION_RAM16;
					case (address[AddrW-1:PageOffW])
						2'd0: begin
							region_d = REGION_ROM16;
							bank_d   = {{(ByteW-1){1'b0}}, rom_choice_q};
						end
						2'd1:    bank_d = SecondSegPage;
						2'd2:    bank_d = ThirdSegPage;
						default: bank_d = {{(ByteW-PageW){1'b0}}, top_page_q};
					endcase
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			region        <= region_d;
			bank_number   <= bank_d;
			offset        <= offset_d;
			write_allowed <= wr_d;
		end
	end

endmodule

[rtl/bmam_chk.sv]
// bmam_chk: port-level checks of the mapper, bound to the top level
// depends on bmam_pkg and banked_memory_address_mapper_unit
module bmam_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [bmam_pkg::ReqW-1:0]     req_type,
	input logic [bmam_pkg::AddrW-1:0]    address,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bmam_pkg::RegionW-1:0]  region,
	input logic [bmam_pkg::ByteW-1:0]    bank_number,
	input logic [bmam_pkg::AddrW-1:0]    offset,
	input logic                          write_allowed
);
	import bmam_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(region) &&
		$stable(bank_number) && $stable(offset) && $stable(write_allowed))
		else $error("result changed while stalled");

	// every accepted transaction shows a result in the next cycle
	a_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after accepted transaction");

	// the unit never refuses a request while no result is pending
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// port writes return an all-zero result
	a_port_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_PORT) |=>
		(region == '0) && (bank_number == '0) && (offset == '0) && !write_allowed)
		else $error("port write result not zero");

	// every translation keeps the low 8K offset bits of its address
	a_offset_low: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_READ || req_type == REQ_WRITE) |=>
		(offset[SlotOffW-1:0] == $past(address[SlotOffW-1:0])))
		else $error("low offset bits lost in translation");

endmodule

bind banked_memory_address_mapper_unit bmam_chk u_bmam_chk (.*);

[tb/banked_memory_address_mapper_unit_tb.sv]
// banked_memory_address_mapper_unit_tb: self-checking testbench of the banked memory address mapper
// drives directed and random requests through both handshakes and predicts every result
// depends on bmam_pkg and banked_memory_address_mapper_unit
`timescale 1ns / 100ps

module banked_memory_address_mapper_unit_tb;
	import bmam_pkg::*;

	typedef struct packed {
		region_t           region;
		logic [ByteW-1:0]  bank;
		logic [AddrW-1:0]  offset;
		logic              wr_ok;
	} mapping_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CfgIdxW-1:0]   cfg_index;
	logic [LimitW-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [ReqW-1:0]      req_type;
	logic [AddrW-1:0]     address;
	logic [PortW-1:0]     port_number;
	logic [ByteW-1:0]     out_value;
	logic                 out_valid;
	logic                 out_ready;
	logic [RegionW-1:0]   region;
	logic [ByteW-1:0]     bank_number;
	logic [AddrW-1:0]     offset;
	logic                 write_allowed;

	// predicted banking state and configuration
	model_t               mdl;
	logic [LimitW-1:0]    lim;
	logic [ByteW-1:0]     slot_map [SlotCnt];
	logic [ByteW-1:0]     sel_reg;
	logic [PageW-1:0]     top_page;
	logic                 rom_sel;
	logic                 locked;

	mapping_t             pending_maps [$];
	int                   mismatch_cnt = 0;
	bit                   gaps_on = 1'b0;
	bit                   stall_on = 1'b0;

	banked_memory_address_mapper_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.address       (address),
		.port_number   (port_number),
		.out_value     (out_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.region        (region),
		.bank_number   (bank_number),
		.offset        (offset),
		.write_allowed (write_allowed)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mapping of one request; port writes update the banking state
	function automatic mapping_t map_request(req_type_t rt, logic [AddrW-1:0] a,
			logic [PortW-1:0] p, logic [ByteW-1:0] v);
		mapping_t m;
		logic [ByteW-1:0] b;
		m.region = REGION_FLAT;
		m.bank   = '0;
		m.offset = '0;
		m.wr_ok  = 1'b0;
		case (rt)
			REQ_PORT: begin
				if (mdl == MODEL_SLOT) begin
					if (p == SelectPort && sel_reg == '0) begin
						sel_reg = v;
					end else begin
						if (sel_reg >= SlotRegFirst && sel_reg <= SlotRegLast)
							slot_map[sel_reg[SlotW-1:0]] = v;
						sel_reg = '0;
					end
				end else if (mdl == MODEL_PAGED && p == PagingPort && !locked) begin
					top_page = v[PageW-1:0];
					rom_sel  = !v[RomBit];
					if (v[LockBit])
						locked = 1'b1;
				end
			end
			REQ_READ, REQ_WRITE: begin
				m.offset = a;
				case (mdl)
					MODEL_SLOT: begin
						b = slot_map[a[AddrW-1:SlotOffW]];
						if (b != Unmapped) begin
							m.region = REGION_BANK8;
							m.bank   = b;
							m.offset = {3'b000, a[SlotOffW-1:0]};
						end
					end
					MODEL_PAGED: begin
						m.offset = {2'b00, a[PageOffW-1:0]};
						case (a[AddrW-1:PageOffW])
							2'd0: begin
								m.region = REGION_ROM16;
								m.bank   = {7'd0, rom_sel};
							end
							2'd1: begin
								m.region = REGION_RAM16;
								m.bank   = SecondSegPage;
							end
							2'd2: begin
								m.region = REGION_RAM16;
								m.bank   = ThirdSegPage;
							end
							default: begin
								m.region = REGION_RAM16;
								m.bank   = {5'd0, top_page};
							end
						endcase
					end
					default: ;
				endcase
				m.wr_ok = ({1'b0, a} >= lim);
			end
			default: ;
		endcase
		return m;
	endfunction

	// one request transaction; valid stays high into the next call unless a gap is drawn
	task automatic send_req(req_type_t rt, logic [AddrW-1:0] a, logic [PortW-1:0] p,
			logic [ByteW-1:0] v);
		int gap;
		gap = gaps_on ? $urandom_range(0, 17) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= rt;
		address     <= a;
		port_number <= p;
		out_value   <= v;
		do @(posedge clk); while (!in_ready);
		pending_maps.push_back(map_request(rt, a, p, v));
	endtask

	task automatic translate(req_type_t rt, logic [AddrW-1:0] a);
		send_req(rt, a, 16'($urandom), 8'($urandom));
	endtask

	task automatic port_write(logic [PortW-1:0] p, logic [ByteW-1:0] v);
		send_req(REQ_PORT, 16'($urandom), p, v);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_maps.size() != 0) @(posedge clk);
	endtask

	// configuration write, only issued while no request is outstanding
	task automatic write_reg(cfg_idx_t idx, logic [LimitW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_MODEL)
			mdl = model_t'(data[ModelW-1:0]);
		else
			lim = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// flat model, write limit extremes, ignored port write, unused request type
	task automatic test_flat_model();
		gaps_on  = 1'b1;
		stall_on = 1'b1;
		translate(REQ_READ, 16'h0000);
		translate(REQ_WRITE, 16'hFFFF);
		port_write(PagingPort, 8'hFF);
		send_req(REQ_NONE, 16'hFFFF, PagingPort, 8'hFF);
		wait_drained();
		write_reg(CFG_ROM_LIMIT, 17'h10000);
		translate(REQ_WRITE, 16'hFFFF);
	endtask

	// eight-slot model: select/data pairs, unmapped slots, non-slot register
	task automatic test_slot_model();
		wait_drained();
		write_reg(CFG_MODEL, LimitW'(MODEL_SLOT));
		write_reg(CFG_ROM_LIMIT, 17'h02000);
		translate(REQ_READ, 16'h0000);
		port_write(SelectPort, SlotRegFirst);
		port_write(16'h0000, 8'h0A);
		translate(REQ_READ, 16'h1FFF);
		translate(REQ_WRITE, 16'h2000);
		port_write(SelectPort, SlotRegLast);
		// data write to the select port itself while a register is selected
		port_write(SelectPort, Unmapped);
		port_write(SelectPort, 8'h12);
		port_write(16'h00FE, 8'h33);
		translate(REQ_READ, 16'hE000);
	endtask

	// 16K paged model: fixed segments, paging port, other ports ignored
	task automatic test_paged_model();
		wait_drained();
		write_reg(CFG_MODEL, LimitW'(MODEL_PAGED));
		write_reg(CFG_ROM_LIMIT, 17'h04000);
		translate(REQ_READ, 16'h3FFF);
		translate(REQ_WRITE, 16'h4000);
		translate(REQ_READ, 16'h8000);
		port_write(PagingPort, 8'h17);
		translate(REQ_READ, 16'hC000);
		translate(REQ_WRITE, 16'h0000);
		port_write(16'h1FFD, 8'h00);
		translate(REQ_READ, 16'hFFFF);
	endtask

	// unused model code behaves as flat; slot state survives model changes
	task automatic test_model_switch();
		wait_drained();
		write_reg(CFG_MODEL, LimitW'(MODEL_ALT));
		translate(REQ_READ, 16'hABCD);
		wait_drained();
		write_reg(CFG_MODEL, LimitW'(MODEL_SLOT));
		translate(REQ_READ, 16'h0000);
	endtask

	// random traffic over several settings, mostly well-formed bank switching
	task automatic test_random_traffic();
		int sent;
		int r;
		logic [AddrW-1:0] a;
		logic [ByteW-1:0] v;
		for (int ph = 0; ph < 12; ph++) begin
			wait_drained();
			write_reg(CFG_MODEL, (ph < 8) ? LimitW'(ph % 4) : LimitW'($urandom_range(0, 3)));
			case (ph % 5)
				0: write_reg(CFG_ROM_LIMIT, 17'h00000);
				1: write_reg(CFG_ROM_LIMIT, 17'h10000);
				2: write_reg(CFG_ROM_LIMIT, 17'h0FFFF);
				3: write_reg(CFG_ROM_LIMIT, LimitW'(16'h4000 * $urandom_range(1, 3)));
				default: write_reg(CFG_ROM_LIMIT, LimitW'($urandom_range(0, 65536)));
			endcase
			gaps_on  = (ph % 3 != 0);
			stall_on = (ph % 4 != 1);
			sent = 0;
			while (sent < 125) begin
				r = $urandom_range(0, 99);
				if (mdl == MODEL_SLOT && r < 30) begin
					v = ($urandom_range(0, 9) == 0) ? 8'($urandom)
						: SlotRegFirst + 8'($urandom_range(0, 7));
					port_write(SelectPort, v);
					port_write(($urandom_range(0, 3) == 0) ? SelectPort : 16'($urandom),
						($urandom_range(0, 4) == 0) ? Unmapped : 8'($urandom));
					sent += 2;
				end else if (mdl == MODEL_PAGED && r < 20) begin
					// keep paging unlocked until the lock test
					v = 8'($urandom);
					v[LockBit] = 1'b0;
					port_write(PagingPort, v);
					sent++;
				end else if (r < 88) begin
					case ($urandom_range(0, 9))
						0: a = 16'h0000;
						1: a = 16'hFFFF;
						2: a = lim[AddrW-1:0] - 16'd1;
						3: a = lim[AddrW-1:0];
						default: a = 16'($urandom);
					endcase
					translate(req_type_t'($urandom_range(0, 1)), a);
					sent++;
				end else if (r < 96) begin
					port_write(16'($urandom), 8'($urandom));
					sent++;
				end else begin
					send_req(REQ_NONE, 16'($urandom), 16'($urandom), 8'($urandom));
					sent++;
				end
			end
		end
	endtask

	// lock bit freezes 128K paging until reset
	task automatic test_paging_lock();
		wait_drained();
		write_reg(CFG_MODEL, LimitW'(MODEL_PAGED));
		write_reg(CFG_ROM_LIMIT, 17'h08000);
		gaps_on  = 1'b1;
		stall_on = 1'b1;
		port_write(PagingPort, 8'h2B);
		port_write(PagingPort, 8'h10);
		translate(REQ_READ, 16'hC000);
		translate(REQ_WRITE, 16'h0000);
		for (int k = 0; k < 20; k++) begin
			if ($urandom_range(0, 1))
				port_write(PagingPort, 8'($urandom));
			else
				translate(req_type_t'($urandom_range(0, 1)), 16'($urandom));
		end
	endtask

	// result side: random stall before each result transaction
	initial begin : result_sink
		int hold;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = stall_on ? $urandom_range(0, 17) : 0;
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		mapping_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_maps.size() == 0) begin
				$error("result transaction with no request outstanding");
				mismatch_cnt++;
			end else begin
				want = pending_maps.pop_front();
				if (region !== want.region) begin
					$error("region: expected %0d, got %0d", want.region, region);
					mismatch_cnt++;
				end
				if (bank_number !== want.bank) begin
					$error("bank_number: expected %0d, got %0d", want.bank, bank_number);
					mismatch_cnt++;
				end
				if (offset !== want.offset) begin
					$error("offset: expected 0x%04h, got 0x%04h", want.offset, offset);
					mismatch_cnt++;
				end
				if (write_allowed !== want.wr_ok) begin
					$error("write_allowed: expected %0b, got %0b", want.wr_ok, write_allowed);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_MODEL;
		cfg_data    = '0;
		in_valid    = 1'b0;
		req_type    = REQ_READ;
		address     = '0;
		port_number = '0;
		out_value   = '0;
		mdl         = MODEL_FLAT;
		lim         = '0;
		foreach (slot_map[i])
			slot_map[i] = Unmapped;
		sel_reg     = '0;
		top_page    = '0;
		rom_sel     = 1'b1;
		locked      = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_flat_model();
		test_slot_model();
		test_paged_model();
		test_model_switch();
		test_random_traffic();
		test_paging_lock();

		wait_drained();
		repeat (3) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// run limit
	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
